>>> src/owbm_pkg.sv
// ---------------------------------------------------------------------------
// owbm_pkg: shared types and constants for the 1-Wire bus master
// Phase and opcode encodings, register indexes and reset values, and the
// structs passed between the register file, the core and the top level.
// ---------------------------------------------------------------------------
package owbm_pkg;

  localparam int unsigned NumRegs  = 8;
  localparam int unsigned RegWidth = 10;
  localparam int unsigned RegIdxW  = 3;

  typedef logic [RegWidth-1:0] reg_val_t;
  typedef reg_val_t [NumRegs-1:0] cfg_regs_t;

  // Register indexes on the configuration port
  typedef enum logic [RegIdxW-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_RESET_TAIL    = 3'd2,
    REG_W1_LOW        = 3'd3,
    REG_W1_RELEASE    = 3'd4,
    REG_W0_LOW        = 3'd5,
    REG_READ_LOW      = 3'd6,
    REG_READ_TAIL     = 3'd7
  } reg_idx_e;

  localparam reg_val_t ResetLowRst     = 10'd500;
  localparam reg_val_t PresenceWaitRst = 10'd65;
  localparam reg_val_t ResetTailRst    = 10'd400;
  localparam reg_val_t W1LowRst        = 10'd1;
  localparam reg_val_t W1ReleaseRst    = 10'd60;
  localparam reg_val_t W0LowRst        = 10'd60;
  localparam reg_val_t ReadLowRst      = 10'd2;
  localparam reg_val_t ReadTailRst     = 10'd60;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_TAIL = 4'd3,
    PH_W1_LOW   = 4'd4,
    PH_W1_REL   = 4'd5,
    PH_W0_LOW   = 4'd6,
    PH_W0_REC   = 4'd7,
    PH_R_LOW    = 4'd8,
    PH_R_SAMPLE = 4'd9,
    PH_R_TAIL   = 4'd10
  } phase_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] tx_byte;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy;
    logic       done;
    logic       presence;
    logic [7:0] rx_byte;
    logic       rejected;
  } result_t;

endpackage

>>> src/owbm_cfg.sv
// ---------------------------------------------------------------------------
// owbm_cfg: timing register file
// Eight 10-bit tick counts, written one beat at a time, read in parallel.
// ---------------------------------------------------------------------------
module owbm_cfg
  import owbm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [RegIdxW-1:0]   wr_idx_i,
  input  reg_val_t             wr_data_i,
  output cfg_regs_t            regs_o
);

  cfg_regs_t regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[REG_RESET_LOW]     <= ResetLowRst;
      regs_q[REG_PRESENCE_WAIT] <= PresenceWaitRst;
      regs_q[REG_RESET_TAIL]    <= ResetTailRst;
      regs_q[REG_W1_LOW]        <= W1LowRst;
      regs_q[REG_W1_RELEASE]    <= W1ReleaseRst;
      regs_q[REG_W0_LOW]        <= W0LowRst;
      regs_q[REG_READ_LOW]      <= ReadLowRst;
      regs_q[REG_READ_TAIL]     <= ReadTailRst;
    end else if (wr_en_i) begin
      regs_q[wr_idx_i] <= wr_data_i;
    end
  end

  assign regs_o = regs_q;

endmodule

>>> src/owbm_core.sv
// ---------------------------------------------------------------------------
// owbm_core: slot sequencer
// Holds the bus phase, slot counter and byte shifter; applies one item
// (tick or command) per go pulse and forms the result for that item.
// ---------------------------------------------------------------------------
module owbm_core
  import owbm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      go_i,
  input  item_t     item_i,
  input  cfg_regs_t cfg_i,
  output result_t   res_o
);

  phase_e     phase_q, phase_d;
  reg_val_t   cnt_q, cnt_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  op_e        op_q, op_d;
  logic       pres_q, pres_d;
  logic [7:0] rx_q, rx_d;

  reg_val_t   cnt_inc;
  logic       busy_q;
  logic       end_bit;
  logic       fin;
  logic       done;
  logic       rejected;
  logic       drive_d;
  logic       busy_d;

  assign cnt_inc = cnt_q + 10'd1;
  assign busy_q  = (phase_q >= PH_RST_LOW) && (phase_q <= PH_R_TAIL);

  // Next state
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    op_d     = op_q;
    pres_d   = pres_q;
    rx_d     = rx_q;
    end_bit  = 1'b0;
    fin      = 1'b0;
    done     = 1'b0;
    rejected = 1'b0;

    if (go_i) begin
      if (item_i.cmd == CMD_TICK) begin
        if (busy_q) begin
          cnt_d = cnt_inc;
          unique case (phase_q)
            PH_RST_LOW: begin
              if (cnt_inc >= cfg_i[REG_RESET_LOW]) begin
                phase_d = PH_RST_WAIT;
                cnt_d   = '0;
              end
            end
            PH_RST_WAIT: begin
              if (cnt_inc >= cfg_i[REG_PRESENCE_WAIT]) begin
                pres_d  = ~item_i.line_level;
                phase_d = PH_RST_TAIL;
                cnt_d   = '0;
                fin     = (cfg_i[REG_RESET_TAIL] == '0);
              end
            end
            PH_RST_TAIL: fin = (cnt_inc >= cfg_i[REG_RESET_TAIL]);
            PH_W1_LOW: begin
              if (cnt_inc >= cfg_i[REG_W1_LOW]) begin
                phase_d = PH_W1_REL;
                cnt_d   = '0;
              end
            end
            PH_W1_REL: end_bit = (cnt_inc >= cfg_i[REG_W1_RELEASE]);
            PH_W0_LOW: begin
              if (cnt_inc >= cfg_i[REG_W0_LOW]) begin
                phase_d = PH_W0_REC;
                cnt_d   = '0;
              end
            end
            PH_W0_REC: begin
              cnt_d   = cnt_q;
              end_bit = 1'b1;
            end
            PH_R_LOW: begin
              if (cnt_inc >= cfg_i[REG_READ_LOW]) begin
                phase_d = PH_R_SAMPLE;
                cnt_d   = '0;
              end
            end
            PH_R_SAMPLE: begin
              shift_d = {item_i.line_level, shift_q[7:1]};
              phase_d = PH_R_TAIL;
              cnt_d   = '0;
              end_bit = (cfg_i[REG_READ_TAIL] == '0);
            end
            PH_R_TAIL: end_bit = (cnt_inc >= cfg_i[REG_READ_TAIL]);
            default: begin
              phase_d = PH_IDLE;
              cnt_d   = '0;
            end
          endcase
        end else begin
          phase_d = PH_IDLE;
        end
      end else if (busy_q) begin
        rejected = 1'b1;
      end else begin
        op_d  = op_e'(item_i.cmd);
        bit_d = '0;
        cnt_d = '0;
        unique case (item_i.cmd)
          CMD_RESET: begin
            shift_d = '0;
            phase_d = PH_RST_LOW;
          end
          CMD_WRITE: begin
            shift_d = item_i.tx_byte;
            phase_d = item_i.tx_byte[0] ? PH_W1_LOW : PH_W0_LOW;
          end
          default: begin
            shift_d = '0;
            phase_d = PH_R_LOW;
          end
        endcase
      end
    end

    // Bit slot finished: step the bit count (and the shifter on writes), then start the next slot or end
    if (end_bit) begin
      if (op_q == OP_WRITE) begin
        shift_d = {1'b0, shift_d[7:1]};
      end
      bit_d = bit_q + 3'd1;
      cnt_d = '0;
      if (bit_d == '0) begin
        fin = 1'b1;
      end else if (op_q == OP_WRITE) begin
        phase_d = shift_d[0] ? PH_W1_LOW : PH_W0_LOW;
      end else begin
        phase_d = PH_R_LOW;
      end
    end

    if (fin) begin
      if (op_q == OP_READ) begin
        rx_d = shift_d;
      end
      phase_d = PH_IDLE;
      cnt_d   = '0;
      done    = 1'b1;
    end
  end

  // Output decode of the phase this item leaves behind
  always_comb begin
    busy_d  = (phase_d >= PH_RST_LOW) && (phase_d <= PH_R_TAIL);
    drive_d = (phase_d == PH_RST_LOW) || (phase_d == PH_W1_LOW) ||
              (phase_d == PH_W0_LOW)  || (phase_d == PH_R_LOW);
  end

  assign res_o.drive_low = drive_d;
  assign res_o.busy      = busy_d;
  assign res_o.done      = done;
  assign res_o.presence  = pres_d;
  assign res_o.rx_byte   = rx_d;
  assign res_o.rejected  = rejected;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      op_q    <= OP_NONE;
      pres_q  <= 1'b0;
      rx_q    <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      op_q    <= op_d;
      pres_q  <= pres_d;
      rx_q    <= rx_d;
    end
  end

endmodule

>>> src/one_wire_bus_master.sv
// ---------------------------------------------------------------------------
// one_wire_bus_master: 1-Wire bus master driven by microsecond ticks
// Input register, slot sequencer and result register around one state update.
// ---------------------------------------------------------------------------
// Each input beat is either one microsecond tick (cmd 0) or a command: bus
// reset with presence detect (1), write byte (2) or read byte (3). Bytes go
// LSB first. Timing of every slot comes from eight 10-bit tick registers on
// the configuration port (always ready, one write per beat); change them only
// while the bus is idle. A command that arrives while an operation runs is
// dropped and flagged with cmd_rejected_o; commands never advance time, only
// ticks do. Every input beat yields exactly one result beat, reflecting the
// state after that beat: drive_low_o tells the pad to pull the line low,
// done_res_o marks the beat that ends an operation, and presence_found_o and
// rx_byte_o hold the last reset and read results.
// Throughput is one beat per clock unless out_ready_i stalls the result
// register: the whole state update (slot counter compare, phase step, bit
// shifter) is a single combinational pass between the input register and
// the result register. The input side stays ready while a result waits as
// long as the input register is empty or moving on.
// ---------------------------------------------------------------------------
module one_wire_bus_master
  import owbm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [RegIdxW-1:0] cfg_index_i,
  input  logic [9:0]         cfg_data_i,
  // Input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [7:0]         tx_byte_i,
  input  logic               line_level_i,
  // Result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               drive_low_o,
  output logic               busy_res_o,
  output logic               done_res_o,
  output logic               presence_found_o,
  output logic [7:0]         rx_byte_o,
  output logic               cmd_rejected_o
);

  cfg_regs_t cfg_regs;
  item_t     item_q;
  logic      in_valid_q;
  logic      out_valid_q;
  result_t   res_d, res_q;
  logic      advance;

  // Register file is always ready for a beat
  assign cfg_ready_o = 1'b1;

  owbm_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .regs_o    (cfg_regs)
  );

  // Item moves into the sequencer when the result register has room
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.cmd        <= cmd_e'(cmd_i);
      item_q.tx_byte    <= tx_byte_i;
      item_q.line_level <= line_level_i;
    end
  end

  owbm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (advance),
    .item_i (item_q),
    .cfg_i  (cfg_regs),
    .res_o  (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign drive_low_o      = res_q.drive_low;
  assign busy_res_o       = res_q.busy;
  assign done_res_o       = res_q.done;
  assign presence_found_o = res_q.presence;
  assign rx_byte_o        = res_q.rx_byte;
  assign cmd_rejected_o   = res_q.rejected;

`ifndef NO_ASSERTIONS
  // A dropped command leaves the running operation in place
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cmd_rejected_o |-> busy_res_o)
    else $error("rejected command reported while idle");

  // Completion returns the bus to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done reported while still busy");

  // The line is only pulled low inside an operation
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drive_low_o |-> busy_res_o)
    else $error("line driven low while idle");

  // Completion needs a tick, rejection needs a command
  a_done_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(done_res_o && cmd_rejected_o))
    else $error("done and rejected on the same beat");
`endif

endmodule
